FILE: rtl/ckk_pkg.sv
package ckk_pkg;

	// default sizes, overridable on the top level
	localparam int COUNT_WIDTH_DEF   = 16;
	localparam int FRACTION_BITS_DEF = 16;

	// fixed field widths of the channels
	localparam int CLASS_W  = 2;
	localparam int KAPPA_W  = 18;
	localparam int STATUS_W = 2;

	// class codes carried by each rater field
	localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_FIRST  = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_SECOND = 2'd2;

	// contingency table cell indexes
	localparam int CELL_BOTH_FIRST  = 0;
	localparam int CELL_TWO_FIRST   = 1;
	localparam int CELL_ONE_FIRST   = 2;
	localparam int CELL_BOTH_SECOND = 3;
	localparam int CELL_COUNT       = 4;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK         = 2'd0,
		STATUS_EMPTY      = 2'd1,
		STATUS_CHANCE_ONE = 2'd2,
		STATUS_SATURATED  = 2'd3
	} ckk_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROW,
		ST_COL,
		ST_NN,
		ST_AGREE,
		ST_SUM,
		ST_PREP,
		ST_START,
		ST_DIV,
		ST_OUT
	} ckk_state_t;

	// datapath operation issued by the controller each cycle
	typedef enum logic [3:0] {
		OP_NONE,
		OP_ROW,
		OP_COL,
		OP_NN,
		OP_AGREE,
		OP_SUM,
		OP_PREP,
		OP_START,
		OP_STEP,
		OP_LOAD
	} ckk_op_t;

	typedef struct packed {
		logic    count;
		logic    clear;
		ckk_op_t op;
	} ckk_cmd_t;

	typedef struct packed {
		logic out_free;
	} ckk_stat_t;

endpackage

FILE: rtl/ckk_in_if.sv
interface ckk_in_if;
	logic                        valid;
	logic                        ready;
	logic [ckk_pkg::CLASS_W-1:0] rater_one_class;
	logic [ckk_pkg::CLASS_W-1:0] rater_two_class;
	logic                        last_item;

	modport source (
		output valid, rater_one_class, rater_two_class, last_item,
		input  ready
	);
	modport sink (
		input  valid, rater_one_class, rater_two_class, last_item,
		output ready
	);
endinterface

FILE: rtl/ckk_out_if.sv
interface ckk_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [ckk_pkg::KAPPA_W-1:0]  kappa;
	logic        [ckk_pkg::STATUS_W-1:0] status;

	modport source (
		output valid, kappa, status,
		input  ready
	);
	modport sink (
		input  valid, kappa, status,
		output ready
	);
endinterface

FILE: rtl/ckk_table.sv
module ckk_table #(
	parameter int COUNT_WIDTH = ckk_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ckk_pkg::ckk_cmd_t           cmd,
	input  logic [ckk_pkg::CLASS_W-1:0] rater_one_class,
	input  logic [ckk_pkg::CLASS_W-1:0] rater_two_class,
	output logic [COUNT_WIDTH-1:0]      n00,
	output logic [COUNT_WIDTH-1:0]      n01,
	output logic [COUNT_WIDTH-1:0]      n10,
	output logic [COUNT_WIDTH-1:0]      n11,
	output logic                        saturated
);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	logic [COUNT_WIDTH-1:0] cnt_q [ckk_pkg::CELL_COUNT];
	logic                   sat_q;
	logic [ckk_pkg::CELL_COUNT-1:0] hit;

	// one-hot cell select; codes outside the two classes select nothing
	always_comb begin
		hit = '0;
		hit[ckk_pkg::CELL_BOTH_FIRST] = (rater_one_class == ckk_pkg::CLASS_FIRST) &&
			(rater_two_class == ckk_pkg::CLASS_FIRST);
		hit[ckk_pkg::CELL_TWO_FIRST] = (rater_one_class == ckk_pkg::CLASS_SECOND) &&
			(rater_two_class == ckk_pkg::CLASS_FIRST);
		hit[ckk_pkg::CELL_ONE_FIRST] = (rater_one_class == ckk_pkg::CLASS_FIRST) &&
			(rater_two_class == ckk_pkg::CLASS_SECOND);
		hit[ckk_pkg::CELL_BOTH_SECOND] = (rater_one_class == ckk_pkg::CLASS_SECOND) &&
			(rater_two_class == ckk_pkg::CLASS_SECOND);
	end

	// saturating counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ckk_pkg::CELL_COUNT; i++) cnt_q[i] <= '0;
			sat_q <= 1'b0;
		end else if (cmd.clear) begin
			for (int i = 0; i < ckk_pkg::CELL_COUNT; i++) cnt_q[i] <= '0;
			sat_q <= 1'b0;
		end else if (cmd.count) begin
			for (int i = 0; i < ckk_pkg::CELL_COUNT; i++) begin
				if (hit[i]) begin
					if (cnt_q[i] == COUNT_MAX) sat_q <= 1'b1;
					else cnt_q[i] <= cnt_q[i] + 1'b1;
				end
			end
		end
	end

	assign n00       = cnt_q[ckk_pkg::CELL_BOTH_FIRST];
	assign n01       = cnt_q[ckk_pkg::CELL_TWO_FIRST];
	assign n10       = cnt_q[ckk_pkg::CELL_ONE_FIRST];
	assign n11       = cnt_q[ckk_pkg::CELL_BOTH_SECOND];
	assign saturated = sat_q;

endmodule

FILE: rtl/ckk_ctrl.sv
module ckk_ctrl #(
	parameter int FRACTION_BITS = ckk_pkg::FRACTION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	output logic                in_ready,
	input  ckk_pkg::ckk_stat_t  stat,
	output ckk_pkg::ckk_cmd_t   cmd
);

	localparam int IW = $clog2(FRACTION_BITS);
	localparam logic [IW-1:0] STEP_LAST = IW'(FRACTION_BITS - 1);

	ckk_pkg::ckk_state_t state_q, state_d;
	logic [IW-1:0]       step_q;

	// state register and division step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ckk_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ckk_pkg::ST_START) step_q <= '0;
			else if (state_q == ckk_pkg::ST_DIV) step_q <= step_q + 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ckk_pkg::ST_IDLE:  if (in_valid && in_last) state_d = ckk_pkg::ST_ROW;
			ckk_pkg::ST_ROW:   state_d = ckk_pkg::ST_COL;
			ckk_pkg::ST_COL:   state_d = ckk_pkg::ST_NN;
			ckk_pkg::ST_NN:    state_d = ckk_pkg::ST_AGREE;
			ckk_pkg::ST_AGREE: state_d = ckk_pkg::ST_SUM;
			ckk_pkg::ST_SUM:   state_d = ckk_pkg::ST_PREP;
			ckk_pkg::ST_PREP:  state_d = ckk_pkg::ST_START;
			ckk_pkg::ST_START: state_d = ckk_pkg::ST_DIV;
			ckk_pkg::ST_DIV:   if (step_q == STEP_LAST) state_d = ckk_pkg::ST_OUT;
			ckk_pkg::ST_OUT:   if (stat.out_free) state_d = ckk_pkg::ST_IDLE;
			default:           state_d = ckk_pkg::ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		in_ready  = 1'b0;
		cmd.count = 1'b0;
		cmd.clear = 1'b0;
		cmd.op    = ckk_pkg::OP_NONE;
		case (state_q)
			ckk_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.count = in_valid;
			end
			ckk_pkg::ST_ROW:   cmd.op = ckk_pkg::OP_ROW;
			ckk_pkg::ST_COL:   cmd.op = ckk_pkg::OP_COL;
			ckk_pkg::ST_NN:    cmd.op = ckk_pkg::OP_NN;
			ckk_pkg::ST_AGREE: cmd.op = ckk_pkg::OP_AGREE;
			ckk_pkg::ST_SUM:   cmd.op = ckk_pkg::OP_SUM;
			ckk_pkg::ST_PREP:  cmd.op = ckk_pkg::OP_PREP;
			ckk_pkg::ST_START: cmd.op = ckk_pkg::OP_START;
			ckk_pkg::ST_DIV:   cmd.op = ckk_pkg::OP_STEP;
			ckk_pkg::ST_OUT: begin
				if (stat.out_free) begin
					cmd.op    = ckk_pkg::OP_LOAD;
					cmd.clear = 1'b1;
				end
			end
			default: cmd.op = ckk_pkg::OP_NONE;
		endcase
	end

endmodule

FILE: rtl/ckk_dpath.sv
module ckk_dpath #(
	parameter int COUNT_WIDTH   = ckk_pkg::COUNT_WIDTH_DEF,
	parameter int FRACTION_BITS = ckk_pkg::FRACTION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ckk_pkg::ckk_cmd_t                  cmd,
	output ckk_pkg::ckk_stat_t                 stat,
	input  logic [COUNT_WIDTH-1:0]             n00,
	input  logic [COUNT_WIDTH-1:0]             n01,
	input  logic [COUNT_WIDTH-1:0]             n10,
	input  logic [COUNT_WIDTH-1:0]             n11,
	input  logic                               saturated,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic signed [ckk_pkg::KAPPA_W-1:0] kappa,
	output logic [ckk_pkg::STATUS_W-1:0]       status
);

	localparam int MW = COUNT_WIDTH + 1;   // marginal
	localparam int NW = COUNT_WIDTH + 2;   // table total
	localparam int PW = 2 * NW;            // products and sums of products
	localparam int QW = FRACTION_BITS + 1; // quotient incl. integer bit
	localparam int KW = ckk_pkg::KAPPA_W;

	logic [MW-1:0] row_a, col_a, row_b, col_b, diag;
	logic [NW-1:0] total;
	logic [NW-1:0] op_a, op_b;
	logic [PW-1:0] prod;

	logic [PW-1:0] s_q, t_q, nn_q, ag_q, den_q, mag_q, rem_q;
	logic          neg_q;
	logic [QW-1:0] quo_q;
	logic          out_valid_q;
	logic signed [KW-1:0]          kappa_q;
	logic [ckk_pkg::STATUS_W-1:0]  status_q;

	logic [PW:0]    shifted, den_ext, diff;
	logic           take;
	logic [QW+KW-1:0] quo_ext, quo_neg;
	logic [KW-1:0]  kappa_val;
	ckk_pkg::ckk_status_t status_val;

	// marginals and total from the table
	always_comb begin
		row_a = MW'(n00) + MW'(n10);
		col_a = MW'(n00) + MW'(n01);
		row_b = MW'(n10) + MW'(n11);
		col_b = MW'(n01) + MW'(n11);
		diag  = MW'(n00) + MW'(n11);
		total = NW'(row_a) + NW'(col_b);
	end

	// shared multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.op)
			ckk_pkg::OP_ROW: begin
				op_a = NW'(row_a);
				op_b = NW'(col_a);
			end
			ckk_pkg::OP_COL: begin
				op_a = NW'(row_b);
				op_b = NW'(col_b);
			end
			ckk_pkg::OP_NN: begin
				op_a = total;
				op_b = total;
			end
			ckk_pkg::OP_AGREE: begin
				op_a = total;
				op_b = NW'(diag);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		prod = op_a * op_b;
	end

	// restoring division step
	always_comb begin
		shifted = {rem_q, 1'b0};
		den_ext = {1'b0, den_q};
		diff    = shifted - den_ext;
		take    = (shifted >= den_ext);
	end

	// result and status selection
	always_comb begin
		quo_ext   = {{KW{1'b0}}, quo_q};
		quo_neg   = '0 - quo_ext;
		kappa_val = neg_q ? quo_neg[KW-1:0] : quo_ext[KW-1:0];
		if (saturated) status_val = ckk_pkg::STATUS_SATURATED;
		else if (total == '0) status_val = ckk_pkg::STATUS_EMPTY;
		else if (den_q == '0) status_val = ckk_pkg::STATUS_CHANCE_ONE;
		else status_val = ckk_pkg::STATUS_OK;
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			ckk_pkg::OP_ROW:   s_q  <= prod;
			ckk_pkg::OP_COL:   t_q  <= prod;
			ckk_pkg::OP_NN:    nn_q <= prod;
			ckk_pkg::OP_AGREE: ag_q <= prod;
			ckk_pkg::OP_SUM:   s_q  <= s_q + t_q;
			ckk_pkg::OP_PREP: begin
				den_q <= nn_q - s_q;
				neg_q <= (ag_q < s_q);
				mag_q <= (ag_q < s_q) ? (s_q - ag_q) : (ag_q - s_q);
			end
			ckk_pkg::OP_START: begin
				// magnitude at or above the denominator clamps to one
				if (mag_q >= den_q) begin
					quo_q <= QW'(1);
					rem_q <= '0;
				end else begin
					quo_q <= '0;
					rem_q <= mag_q;
				end
			end
			ckk_pkg::OP_STEP: begin
				quo_q <= {quo_q[QW-2:0], take};
				if (take) rem_q <= diff[PW-1:0];
				else rem_q <= shifted[PW-1:0];
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == ckk_pkg::OP_LOAD) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == ckk_pkg::OP_LOAD) begin
			status_q <= status_val;
			kappa_q  <= (status_val == ckk_pkg::STATUS_OK) ? $signed(kappa_val) : '0;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign kappa         = kappa_q;
	assign status        = status_q;

endmodule

FILE: rtl/cohen_kappa_two_class.sv
// Cohen's kappa for two raters and two classes. Each rating beat carries one class
// code per rater; a beat is counted into a 2x2 table of saturating counters when
// both codes name a class, and skipped otherwise. A beat with last_item set is
// counted, then the block forms kappa = (N*(n00+n11) - S) / (N*N - S) exactly and
// returns one result beat: kappa in signed Q1.FRACTION_BITS truncated toward zero,
// cut to 18 bits, plus a status (ok, empty table, chance agreement one, counter
// saturated; kappa reads zero unless ok). The table then clears. An ordinary beat
// never holds off the beat behind it. After a last beat the block stops taking beats
// during four passes through one shared multiplier, three add/subtract steps and a
// restoring divider that retires one quotient bit per cycle; it then waits only
// while the previous result has not been taken.
module cohen_kappa_two_class #(
	parameter int COUNT_WIDTH   = ckk_pkg::COUNT_WIDTH_DEF,
	parameter int FRACTION_BITS = ckk_pkg::FRACTION_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ckk_in_if.sink    rating,
	ckk_out_if.source result
);

	ckk_pkg::ckk_cmd_t  cmd;
	ckk_pkg::ckk_stat_t stat;

	logic [COUNT_WIDTH-1:0] n00, n01, n10, n11;
	logic                   saturated;

	ckk_ctrl #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(rating.valid),
		.in_last (rating.last_item),
		.in_ready(rating.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	ckk_table #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_table (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.rater_one_class(rating.rater_one_class),
		.rater_two_class(rating.rater_two_class),
		.n00            (n00),
		.n01            (n01),
		.n10            (n10),
		.n11            (n11),
		.saturated      (saturated)
	);

	ckk_dpath #(
		.COUNT_WIDTH  (COUNT_WIDTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.n00      (n00),
		.n01      (n01),
		.n10      (n10),
		.n11      (n11),
		.saturated(saturated),
		.out_ready(result.ready),
		.out_valid(result.valid),
		.kappa    (result.kappa),
		.status   (result.status)
	);

endmodule

FILE: rtl/ckk_check.sv
module ckk_check (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               in_last,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [ckk_pkg::KAPPA_W-1:0] kappa,
	input logic [ckk_pkg::STATUS_W-1:0]       status
);

	localparam logic signed [ckk_pkg::KAPPA_W-1:0] KAPPA_ONE = 18'sd65536;

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kappa) && $stable(status))
		else $error("result beat changed while stalled");

	// a last beat starts the computation and blocks further beats
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("rating accepted right after a last beat");

	// an ordinary beat never stalls the next one
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_last |=> in_ready)
		else $error("rating stalled after an ordinary beat");

	// any non-ok status carries a zero kappa
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ckk_pkg::STATUS_OK) |-> kappa == '0)
		else $error("kappa nonzero with error status");

	// kappa stays within minus one to one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ckk_pkg::STATUS_OK) |-> (kappa <= KAPPA_ONE) &&
		(kappa >= -KAPPA_ONE))
		else $error("kappa out of range");

endmodule

bind cohen_kappa_two_class ckk_check u_ckk_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (rating.valid),
	.in_ready (rating.ready),
	.in_last  (rating.last_item),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.kappa    (result.kappa),
	.status   (result.status)
);

FILE: tb/sv/tb_cohen_kappa_two_class.sv
`timescale 1ns / 1ps

module tb_cohen_kappa_two_class;

	localparam int COUNT_W    = ckk_pkg::COUNT_WIDTH_DEF;
	localparam int FRAC_W     = ckk_pkg::FRACTION_BITS_DEF;
	localparam int CLS_W      = ckk_pkg::CLASS_W;
	localparam int KAP_W      = ckk_pkg::KAPPA_W;
	localparam int GAP_PCT    = 28;
	localparam int RANDOM_LEN = 930;
	localparam int HOLD_LEN   = 500;
	localparam int DRAIN_LEN  = 2 * (FRAC_W + 8) + 16;
	localparam int CYCLE_CAP  = 400000;

	// unused code, behaves like neither class
	localparam logic [CLS_W-1:0] CLASS_RESERVED = 2'd3;

	typedef struct {
		logic [CLS_W-1:0] one_cls;
		logic [CLS_W-1:0] two_cls;
		logic             last;
		bit               burst;
	} rating_beat_t;

	typedef struct {
		logic signed [KAP_W-1:0] kappa;
		ckk_pkg::ckk_status_t    status;
	} kappa_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ckk_in_if  rating_ch ();
	ckk_out_if result_ch ();

	cohen_kappa_two_class #(
		.COUNT_WIDTH   (COUNT_W),
		.FRACTION_BITS (FRAC_W)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rating (rating_ch),
		.result (result_ch)
	);

	// pending rating beats and expected kappa results
	rating_beat_t  rating_q [$];
	kappa_result_t kappa_expected [$];
	rating_beat_t  on_wire = '{default: '0};

	// predictor copy of the contingency table
	logic [COUNT_W-1:0] tally [ckk_pkg::CELL_COUNT];
	bit                 tally_saturated;

	int  beats_taken = 0;
	int  hold_at = 32'h7fffffff;
	bit  hold_done = 1'b0;
	int  hold_left = 0;
	int  error_count = 0;
	int  cycle_count = 0;

	always #2 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// update the table for one beat; on a last beat form the kappa result
	function automatic bit kappa_predict(input rating_beat_t beat, output kappa_result_t res);
		longint unsigned n00, n01, n10, n11, total, chance, agree, den, mag;
		logic [127:0]     scaled;
		logic [KAP_W-1:0] quot;
		bit               neg;
		int               slot;
		slot = -1;
		res.kappa = '0;
		res.status = ckk_pkg::STATUS_OK;
		if (beat.one_cls == ckk_pkg::CLASS_FIRST && beat.two_cls == ckk_pkg::CLASS_FIRST)
			slot = ckk_pkg::CELL_BOTH_FIRST;
		else if (beat.one_cls == ckk_pkg::CLASS_SECOND &&
				beat.two_cls == ckk_pkg::CLASS_FIRST)
			slot = ckk_pkg::CELL_TWO_FIRST;
		else if (beat.one_cls == ckk_pkg::CLASS_FIRST &&
				beat.two_cls == ckk_pkg::CLASS_SECOND)
			slot = ckk_pkg::CELL_ONE_FIRST;
		else if (beat.one_cls == ckk_pkg::CLASS_SECOND &&
				beat.two_cls == ckk_pkg::CLASS_SECOND)
			slot = ckk_pkg::CELL_BOTH_SECOND;
		if (slot >= 0) begin
			if (tally[slot] == '1)
				tally_saturated = 1'b1;
			else
				tally[slot] = tally[slot] + 1'b1;
		end
		if (!beat.last)
			return 1'b0;

		n00 = 64'(tally[ckk_pkg::CELL_BOTH_FIRST]);
		n01 = 64'(tally[ckk_pkg::CELL_TWO_FIRST]);
		n10 = 64'(tally[ckk_pkg::CELL_ONE_FIRST]);
		n11 = 64'(tally[ckk_pkg::CELL_BOTH_SECOND]);
		total = n00 + n01 + n10 + n11;
		chance = (n00 + n10) * (n00 + n01) + (n10 + n11) * (n01 + n11);
		agree = total * (n00 + n11);
		den = total * total - chance;
		if (tally_saturated) begin
			res.status = ckk_pkg::STATUS_SATURATED;
		end else if (total == 0) begin
			res.status = ckk_pkg::STATUS_EMPTY;
		end else if (den == 0) begin
			res.status = ckk_pkg::STATUS_CHANCE_ONE;
		end else begin
			neg = agree < chance;
			mag = neg ? chance - agree : agree - chance;
			if (mag > den)
				mag = den;
			scaled = ({64'd0, mag} << FRAC_W) / {64'd0, den};
			quot = scaled[KAP_W-1:0];
			if (neg)
				quot = -quot;
			res.kappa = quot;
		end
		foreach (tally[i])
			tally[i] = '0;
		tally_saturated = 1'b0;
		return 1'b1;
	endfunction

	task automatic push_rating(input logic [CLS_W-1:0] one_cls,
			input logic [CLS_W-1:0] two_cls, input logic last, input bit burst);
		rating_beat_t beat;
		beat.one_cls = one_cls;
		beat.two_cls = two_cls;
		beat.last = last;
		beat.burst = burst;
		rating_q.push_back(beat);
	endtask

	// sender: offers queued beats, holds each until taken, predicts on acceptance
	always @(posedge clk) begin
		kappa_result_t res;
		rating_beat_t  beat;
		bit            taken;
		if (!arst_n) begin
			rating_ch.valid <= 1'b0;
		end else begin
			taken = rating_ch.valid && rating_ch.ready;
			if (taken) begin
				if (kappa_predict(on_wire, res))
					kappa_expected.push_back(res);
				beats_taken <= beats_taken + 1;
			end
			if (!rating_ch.valid || taken) begin
				if (rating_q.size() != 0 &&
						(rating_q[0].burst || $urandom_range(99) >= GAP_PCT)) begin
					beat = rating_q.pop_front();
					rating_ch.valid <= 1'b1;
					rating_ch.rater_one_class <= beat.one_cls;
					rating_ch.rater_two_class <= beat.two_cls;
					rating_ch.last_item <= beat.last;
					on_wire <= beat;
				end else begin
					rating_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random back-pressure plus one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (!hold_done && beats_taken >= hold_at) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN - 1;
			result_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= on_wire.burst || $urandom_range(99) >= GAP_PCT;
		end
	end

	// result checker
	always @(posedge clk) begin
		kappa_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (kappa_expected.size() == 0) begin
				report_mismatch($sformatf("unexpected result kappa=%0d status=%0d",
					result_ch.kappa, result_ch.status));
			end else begin
				want = kappa_expected.pop_front();
				if (result_ch.kappa !== want.kappa)
					report_mismatch($sformatf("kappa got %0d want %0d",
						result_ch.kappa, want.kappa));
				if (result_ch.status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d",
						result_ch.status, want.status));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("tb_cohen_kappa_two_class NOT OK");
			$finish;
		end
	end

	initial begin
		int               counted;
		int               set_len;
		int               agree_pct;
		bit               one_class_set;
		logic [CLS_W-1:0] a, b;

		rating_ch.valid = 1'b0;
		rating_ch.rater_one_class = ckk_pkg::CLASS_NONE;
		rating_ch.rater_two_class = ckk_pkg::CLASS_NONE;
		rating_ch.last_item = 1'b0;
		result_ch.ready = 1'b0;
		foreach (tally[i])
			tally[i] = '0;
		tally_saturated = 1'b0;

		// empty set, then reserved codes only
		push_rating(ckk_pkg::CLASS_NONE, ckk_pkg::CLASS_NONE, 1'b1, 1'b0);
		push_rating(CLASS_RESERVED, ckk_pkg::CLASS_FIRST, 1'b0, 1'b0);
		push_rating(ckk_pkg::CLASS_FIRST, CLASS_RESERVED, 1'b0, 1'b0);
		push_rating(CLASS_RESERVED, CLASS_RESERVED, 1'b1, 1'b0);
		// one class only: chance agreement one
		push_rating(ckk_pkg::CLASS_FIRST, ckk_pkg::CLASS_FIRST, 1'b0, 1'b0);
		push_rating(ckk_pkg::CLASS_FIRST, ckk_pkg::CLASS_FIRST, 1'b1, 1'b0);
		push_rating(ckk_pkg::CLASS_SECOND, ckk_pkg::CLASS_SECOND, 1'b1, 1'b0);
		// perfect agreement and perfect disagreement
		push_rating(ckk_pkg::CLASS_FIRST, ckk_pkg::CLASS_FIRST, 1'b0, 1'b0);
		push_rating(ckk_pkg::CLASS_SECOND, ckk_pkg::CLASS_SECOND, 1'b1, 1'b0);
		push_rating(ckk_pkg::CLASS_FIRST, ckk_pkg::CLASS_SECOND, 1'b0, 1'b0);
		push_rating(ckk_pkg::CLASS_SECOND, ckk_pkg::CLASS_FIRST, 1'b1, 1'b0);
		// mixed table with a skipped beat inside
		push_rating(ckk_pkg::CLASS_FIRST, ckk_pkg::CLASS_FIRST, 1'b0, 1'b0);
		push_rating(ckk_pkg::CLASS_FIRST, ckk_pkg::CLASS_SECOND, 1'b0, 1'b0);
		push_rating(ckk_pkg::CLASS_SECOND, ckk_pkg::CLASS_SECOND, 1'b0, 1'b0);
		push_rating(ckk_pkg::CLASS_SECOND, ckk_pkg::CLASS_FIRST, 1'b0, 1'b0);
		push_rating(ckk_pkg::CLASS_FIRST, ckk_pkg::CLASS_FIRST, 1'b0, 1'b0);
		push_rating(ckk_pkg::CLASS_NONE, ckk_pkg::CLASS_SECOND, 1'b0, 1'b0);
		push_rating(ckk_pkg::CLASS_SECOND, ckk_pkg::CLASS_SECOND, 1'b1, 1'b0);
		// last beat itself skipped
		push_rating(ckk_pkg::CLASS_SECOND, ckk_pkg::CLASS_FIRST, 1'b0, 1'b0);
		push_rating(ckk_pkg::CLASS_FIRST, ckk_pkg::CLASS_FIRST, 1'b0, 1'b0);
		push_rating(ckk_pkg::CLASS_NONE, ckk_pkg::CLASS_NONE, 1'b1, 1'b0);

		// random sets; the first stretch runs with no gaps on either side
		hold_at = rating_q.size() + 300;
		counted = 0;
		while (counted < RANDOM_LEN) begin
			set_len = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 12);
			agree_pct = $urandom_range(0, 100);
			one_class_set = $urandom_range(9) == 0;
			for (int k = 0; k < set_len; k++) begin
				if ($urandom_range(99) < 8) begin
					a = CLS_W'($urandom_range(0, 3));
					b = CLS_W'($urandom_range(0, 3));
				end else if (one_class_set) begin
					a = agree_pct[0] ? ckk_pkg::CLASS_FIRST : ckk_pkg::CLASS_SECOND;
					b = a;
				end else begin
					a = CLS_W'($urandom_range(ckk_pkg::CLASS_FIRST, ckk_pkg::CLASS_SECOND));
					b = ($urandom_range(99) < agree_pct) ? a :
						((a == ckk_pkg::CLASS_FIRST) ? ckk_pkg::CLASS_SECOND :
						ckk_pkg::CLASS_FIRST);
				end
				push_rating(a, b, k == set_len - 1, counted < 150);
				counted++;
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain, then let the block settle
		while (rating_q.size() != 0 || rating_ch.valid || kappa_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_LEN) @(posedge clk);
		if (kappa_expected.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", kappa_expected.size()));
		if (error_count == 0)
			$display("tb_cohen_kappa_two_class OK");
		else
			$display("tb_cohen_kappa_two_class NOT OK");
		$finish;
	end

endmodule

FILE: files.f
rtl/ckk_pkg.sv
rtl/ckk_in_if.sv
rtl/ckk_out_if.sv
rtl/ckk_table.sv
rtl/ckk_ctrl.sv
rtl/ckk_dpath.sv
rtl/cohen_kappa_two_class.sv
rtl/ckk_check.sv
tb/sv/tb_cohen_kappa_two_class.sv
